[rtl/pdmr_pkg.sv]
// shared constants, types and register map of the pdm microphone register model
// used by the top level, the shadow store and the checker
// no dependencies
package pdmr_pkg;

    localparam int DEF_CHANNELS     = 3;
    localparam int DEF_WINDOW_WORDS = 256;

    localparam int OFF_W      = 10;
    localparam int DATA_W     = 32;
    localparam int SHADOW_AW  = 8;
    localparam int SAMPLE_W   = 20;
    localparam int PHASE_W    = 6;
    localparam int IN_TDATA_W = 48;

    // access kinds carried in tuser
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // register map
    localparam logic [OFF_W-1:0] OFS_START  = 10'h000;
    localparam logic [OFF_W-1:0] OFS_STOP   = 10'h004;
    localparam logic [OFF_W-1:0] OFS_STATUS = 10'h010;
    localparam logic [7:0]       BANK_ENABLE = 8'hE0;
    localparam logic [7:0]       BANK_DATA   = 8'hE8;
    localparam logic [7:0]       BANK_FILL   = 8'hEC;
    localparam logic [DATA_W-1:0] FILL_LIVE  = 32'd32;

    // tone and dither generator
    localparam logic [DATA_W-1:0]   LCG_MUL     = 32'd1664525;
    localparam logic [DATA_W-1:0]   LCG_ADD     = 32'd1013904223;
    localparam logic [SAMPLE_W-1:0] TRI_AMP     = 20'd20000;
    localparam logic [SAMPLE_W-1:0] TRI_STEP    = 20'd1250;
    localparam logic [SAMPLE_W-1:0] DITHER_BIAS = 20'd512;

    typedef struct packed {
        logic                 en;
        logic [SHADOW_AW-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_shadow_wr;

endpackage

[rtl/pdmr_shadow.sv]
// shadow word store: one synchronous memory with a registered read port
// per-word valid bits cleared at reset make unwritten words read as zero
// depends on pdmr_pkg
module pdmr_shadow
    import pdmr_pkg::*;
#(
    parameter int WINDOW_WORDS = DEF_WINDOW_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [SHADOW_AW-1:0] i_rd_addr,
    input  t_shadow_wr           i_wr,
    output logic [DATA_W-1:0]    o_rd_data
);

    localparam int AW = $clog2(WINDOW_WORDS);

    logic [DATA_W-1:0]       r_mem [WINDOW_WORDS];
    logic [WINDOW_WORDS-1:0] r_valid;
    logic [DATA_W-1:0]       r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr[AW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/pdm_mic_register_model_unit.sv]
// top level of the pdm microphone register model: bus sequencer, channel state memory,
// tone and dither datapath and output register
// depends on pdmr_pkg and pdmr_shadow
//
// One bus access is taken at a time. A write passes through S_EXEC before the next
// access can be taken, a flag, fill count or shadow word read through S_EXEC and S_OUT,
// and a live channel's data register read through S_EXEC, S_MIX and S_OUT. Both memory
// reads are registered at acceptance, the generator product in S_EXEC, the sample in
// S_MIX and the output register in S_OUT. The result waits there, so new accesses are
// taken while it is held; a further read then waits in its last step until the held
// result is taken. Reset clears the run and enable flags and the valid bits of both
// memories at once; no clearing pass is needed and the block is ready just after reset.
module pdm_mic_register_model_unit
    import pdmr_pkg::*;
#(
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int WINDOW_WORDS = DEF_WINDOW_WORDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [9:0] byte_offset, [41:10] write_data, [47:42] zero
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    // [0] func
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [31:0] read_data
    output logic [DATA_W-1:0]     o_m_axis_tdata
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CST_W = PHASE_W + DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MIX,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_func;
    logic [OFF_W-1:0]    r_off;
    logic [DATA_W-1:0]   r_wd;
    logic [DATA_W-1:0]   r_res;
    logic [DATA_W-1:0]   r_prod;
    logic [PHASE_W-1:0]  r_phase;
    logic [CHANNELS-1:0] r_run;
    logic [CHANNELS-1:0] r_ren;
    logic                r_m_valid;
    logic [DATA_W-1:0]   r_m_data;

    // channel state memory {phase, generator}
    logic [CST_W-1:0]    r_chan_mem [CHANNELS];
    logic [CHANNELS-1:0] r_cvalid;
    logic [CST_W-1:0]    r_chan_rd;
    logic                r_chan_rd_vld;

    logic                s_acc;
    logic [OFF_W-1:0]    in_off;
    logic [1:0]          in_n;
    logic                in_hit;
    logic [CH_W-1:0]     in_idx;

    logic [1:0]          bank_n;
    logic                bank_hit;
    logic [CH_W-1:0]     ch;
    logic [7:0]          rel;
    logic                live;

    logic [PHASE_W-1:0]  chan_phase;
    logic [DATA_W-1:0]   chan_gen;
    logic [DATA_W-1:0]   prod;
    logic [DATA_W-1:0]   n_gen;
    logic [SAMPLE_W-1:0] step;
    logic [SAMPLE_W-1:0] tri_v;
    logic [SAMPLE_W-1:0] dither;
    logic [SAMPLE_W-1:0] sample;
    logic                chan_we;

    t_shadow_wr          shadow_wr;
    logic [DATA_W-1:0]   shadow_rd;

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // decode of the incoming transaction for the memory read addresses
    assign in_off = i_s_axis_tdata[OFF_W-1:0];
    assign in_n   = in_off[9:8] - 2'd1;
    assign in_hit = (in_off[9:8] != 2'd0) && (32'(in_n) < CHANNELS);
    assign in_idx = in_hit ? in_n[CH_W-1:0] : '0;

    // decode of the held transaction
    assign bank_n   = r_off[9:8] - 2'd1;
    assign bank_hit = (r_off[9:8] != 2'd0) && (32'(bank_n) < CHANNELS);
    assign ch       = bank_hit ? bank_n[CH_W-1:0] : '0;
    assign rel      = r_off[7:0];
    assign live     = r_run[ch] && r_ren[ch];

    assign chan_phase = r_chan_rd_vld ? r_chan_rd[CST_W-1:DATA_W] : '0;
    assign chan_gen   = r_chan_rd_vld ? r_chan_rd[DATA_W-1:0] : '0;
    assign prod       = chan_gen * LCG_MUL;

    // triangle: falls from the top in the upper half of the period
    assign n_gen  = r_prod + LCG_ADD;
    assign step   = TRI_STEP * {{(SAMPLE_W-5){1'b0}}, r_phase[4:0]};
    assign tri_v  = r_phase[5] ? (TRI_AMP - step) : (step - TRI_AMP);
    assign dither = {{(SAMPLE_W-10){1'b0}}, n_gen[25:16]} - DITHER_BIAS;
    assign sample = tri_v + dither;

    assign chan_we = (r_state == S_MIX);

    assign shadow_wr.en   = (r_state == S_EXEC) && (r_func == FUNC_WRITE);
    assign shadow_wr.addr = r_off[OFF_W-1:2];
    assign shadow_wr.data = r_wd;

    pdmr_shadow #(
        .WINDOW_WORDS(WINDOW_WORDS)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (in_off[OFF_W-1:2]),
        .i_wr      (shadow_wr),
        .o_rd_data (shadow_rd)
    );

    always_ff @(posedge i_clk) begin
        if (chan_we) begin
            r_chan_mem[ch] <= {r_phase + 6'd1, n_gen};
        end
        if (s_acc) begin
            r_chan_rd <= r_chan_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_run         <= '0;
            r_ren         <= '0;
            r_cvalid      <= '0;
            r_chan_rd_vld <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            // in S_OUT the output register is handled by the state itself
            if (r_m_valid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_func        <= i_s_axis_tuser;
                        r_off         <= in_off;
                        r_wd          <= i_s_axis_tdata[OFF_W +: DATA_W];
                        r_chan_rd_vld <= r_cvalid[in_idx];
                        r_state       <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_func == FUNC_WRITE) begin
                        if (r_off == OFS_START) begin
                            r_run <= r_run | r_wd[CHANNELS-1:0];
                        end else if (r_off == OFS_STOP) begin
                            r_run <= r_run & ~r_wd[CHANNELS-1:0];
                        end else if (bank_hit && rel == BANK_ENABLE) begin
                            r_ren[ch] <= r_wd[0];
                        end
                        r_state <= S_IDLE;
                    end else begin
                        priority if (r_off == OFS_STATUS) begin
                            r_res   <= 32'(r_run);
                            r_state <= S_OUT;
                        end else if (bank_hit && (rel == BANK_FILL || rel == BANK_DATA)) begin
                            if (!live) begin
                                r_res   <= '0;
                                r_state <= S_OUT;
                            end else if (rel == BANK_FILL) begin
                                r_res   <= FILL_LIVE;
                                r_state <= S_OUT;
                            end else begin
                                r_prod  <= prod;
                                r_phase <= chan_phase;
                                r_state <= S_MIX;
                            end
                        end else begin
                            r_res   <= shadow_rd;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MIX: begin
                    r_cvalid[ch] <= 1'b1;
                    r_res        <= {{(DATA_W-SAMPLE_W){1'b0}}, sample};
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data  <= r_res;
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/pdmr_checker.sv]
// port-level checker for the pdm microphone register model, bound to the top level
// depends on pdmr_pkg and pdm_mic_register_model_unit
module pdmr_checker
    import pdmr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input logic                  i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [DATA_W-1:0]     o_m_axis_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic       rd_acc;
    logic [1:0] r_pend;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign rd_acc = s_acc && (i_s_axis_tuser == FUNC_READ) && (i_s_axis_tdata[47:42] == 6'd0);

    // reads accepted whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, s_acc && (i_s_axis_tuser == FUNC_READ)}
                    - {1'b0, m_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("transaction taken while the previous one is in progress");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_pend != 2'd0)
        else $error("result presented without an outstanding read");

    a_read_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc && r_pend == 2'd0 |=> !o_m_axis_tvalid)
        else $error("read result presented in the cycle after acceptance");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("handshake not cleared by reset");

endmodule

bind pdm_mic_register_model_unit pdmr_checker u_pdmr_checker (.*);

[bench/pdmr_access_checker.sv]
// checker for the pdm microphone register model: watches both stream channels,
// keeps its own copy of the register state and compares every read result
// depends on pdmr_pkg
module pdmr_access_checker
    import pdmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // [9:0] byte_offset, [41:10] write_data, [47:42] zero
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    // [0] func
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] read_data
    input  logic [DATA_W-1:0]     i_m_tdata,
    output logic [31:0]           o_fail_count,
    output logic [31:0]           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = DEF_CHANNELS;

    logic               run_on     [NCH];
    logic               rd_en      [NCH];
    logic [PHASE_W-1:0] tone_phase [NCH];
    logic [DATA_W-1:0]  dither_lcg [NCH];
    logic [DATA_W-1:0]  shadow     [DEF_WINDOW_WORDS];
    logic [DATA_W-1:0]  pending_reads [$];
    logic [DATA_W-1:0]  want;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_v);
        o_fail_count = o_fail_count + 1;
        $display("[%0t] mismatch: %s: got %08h, expected %08h", $time, what, got, exp_v);
    endtask

    // triangle tone plus lcg dither, advances phase and generator
    function automatic logic [DATA_W-1:0] next_tone_sample(input int ch);
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] tone_v;
        logic [DATA_W-1:0] g;
        logic [DATA_W-1:0] dith;
        p = DATA_W'(tone_phase[ch]);
        if (p < 32) begin
            tone_v = 32'd0 - DATA_W'(TRI_AMP) + DATA_W'(TRI_STEP) * p;
        end else begin
            tone_v = DATA_W'(TRI_AMP) - DATA_W'(TRI_STEP) * (p - 32);
        end
        g = dither_lcg[ch] * LCG_MUL + LCG_ADD;
        dither_lcg[ch] = g;
        dith = ((g >> 16) & 32'h0000_03FF) - DATA_W'(DITHER_BIAS);
        tone_phase[ch] = tone_phase[ch] + 1'b1;
        return (tone_v + dith) & 32'h000F_FFFF;
    endfunction

    task automatic apply_access(input logic func, input logic [OFF_W-1:0] off,
                                input logic [DATA_W-1:0] wd);
        logic [SHADOW_AW-1:0] word;
        logic [7:0]           rel;
        logic [DATA_W-1:0]    rd;
        int                   ch;
        word = off[OFF_W-1:2];
        rel  = off[7:0];
        ch   = (off >= 10'h100) ? int'(off[9:8]) - 1 : -1;
        if (ch >= NCH) begin
            ch = -1;
        end
        if (func == FUNC_WRITE) begin
            shadow[word] = wd;
            if (off == OFS_START || off == OFS_STOP) begin
                for (int i = 0; i < NCH; i++) begin
                    if (wd[i]) begin
                        run_on[i] = (off == OFS_START);
                    end
                end
            end else if (ch >= 0 && rel == BANK_ENABLE) begin
                rd_en[ch] = wd[0];
            end
        end else begin
            if (off == OFS_STATUS) begin
                rd = '0;
                for (int i = 0; i < NCH; i++) begin
                    rd[i] = run_on[i];
                end
            end else if (ch >= 0 && (rel == BANK_FILL || rel == BANK_DATA)) begin
                if (!(run_on[ch] && rd_en[ch])) begin
                    rd = '0;
                end else if (rel == BANK_FILL) begin
                    rd = FILL_LIVE;
                end else begin
                    rd = next_tone_sample(ch);
                end
            end else begin
                rd = shadow[word];
            end
            pending_reads.push_back(rd);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                run_on[i]     = 1'b0;
                rd_en[i]      = 1'b0;
                tone_phase[i] = '0;
                dither_lcg[i] = '0;
            end
            for (int i = 0; i < DEF_WINDOW_WORDS; i++) begin
                shadow[i] = '0;
            end
            pending_reads.delete();
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                apply_access(i_s_tuser, i_s_tdata[OFF_W-1:0], i_s_tdata[OFF_W +: DATA_W]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch("result transaction with no read outstanding",
                                    i_m_tdata, '0);
                end else begin
                    want = pending_reads.pop_front();
                    if (i_m_tdata !== want) begin
                        report_mismatch("read_data", i_m_tdata, want);
                    end
                end
            end
        end
        o_pending = pending_reads.size();
    end

endmodule

[bench/tb_pdm_mic_register_model_unit.sv]
// testbench top for pdm_mic_register_model_unit: clock, reset, access stimulus
// with random gaps and back-pressure, and the final verdict
// depends on pdmr_pkg, pdm_mic_register_model_unit and pdmr_access_checker
module tb_pdm_mic_register_model_unit
    import pdmr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_AT      = 120;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 250_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_TDATA_W-1:0] s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [DATA_W-1:0]     m_data;
    logic [31:0]           fail_count;
    logic [31:0]           pending;

    int items_sent;
    bit quiet_send;

    pdm_mic_register_model_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    pdmr_access_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_access(input logic func, input logic [OFF_W-1:0] off,
                               input logic [DATA_W-1:0] wd);
        int gap;
        gap = quiet_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= IN_TDATA_W'({wd, off});
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off
    initial begin
        int  stall;
        int  stretch;
        bit  calm;
        bit  held;
        int  r;
        stall   = 0;
        stretch = 0;
        calm    = 1'b0;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && items_sent >= HOLD_AT) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stretch == 0) begin
                calm    = ($urandom_range(0, 2) == 0);
                stretch = $urandom_range(20, 80);
            end
            stretch--;
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 30) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    stall = $urandom_range(0, 2);
                end else if (r < 95) begin
                    stall = $urandom_range(3, 11);
                end else begin
                    stall = $urandom_range(30, 80);
                end
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int               r;
        int               len;
        int               ch;
        int               target;
        logic [OFF_W-1:0] bank;
        items_sent = 0;
        quiet_send = 1'b0;
        s_valid    = 1'b0;
        s_user     = FUNC_READ;
        s_data     = '0;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all idle after reset
        send_access(FUNC_READ,  OFS_STATUS, 32'h0000_0000);
        send_access(FUNC_READ,  10'h1E8,    32'hFFFF_FFFF);
        send_access(FUNC_READ,  10'h1EC,    32'h0000_0000);
        // start everything, bits beyond the channels only land in the shadow word
        send_access(FUNC_WRITE, OFS_START,  32'hFFFF_FFFF);
        send_access(FUNC_READ,  OFS_STATUS, 32'h0000_0000);
        send_access(FUNC_READ,  OFS_START,  32'h0000_0000);
        // running but not read-enabled
        send_access(FUNC_READ,  10'h1EC,    32'h0000_0000);
        send_access(FUNC_WRITE, 10'h1E0,    32'h0000_0001);
        send_access(FUNC_READ,  10'h1EC,    32'h0000_0000);
        send_access(FUNC_READ,  10'h1E8,    32'h0000_0000);
        send_access(FUNC_READ,  10'h1E8,    32'h0000_0000);
        send_access(FUNC_WRITE, 10'h2E0,    32'hFFFF_FFFF);
        send_access(FUNC_WRITE, 10'h3E0,    32'h0000_0001);
        send_access(FUNC_READ,  10'h2E8,    32'h0000_0000);
        send_access(FUNC_READ,  10'h3E8,    32'h0000_0000);
        send_access(FUNC_READ,  10'h3EC,    32'h0000_0000);
        // unaligned byte of the enable word: shadow only, channel stays live
        send_access(FUNC_WRITE, 10'h1E1,    32'h0000_0000);
        send_access(FUNC_READ,  10'h1E8,    32'h0000_0000);
        // data offset write is latched only, visible through an unaligned read
        send_access(FUNC_WRITE, 10'h1E8,    32'hDEAD_BEEF);
        send_access(FUNC_READ,  10'h1EB,    32'h0000_0000);
        send_access(FUNC_WRITE, OFS_STOP,   32'h0000_0002);
        send_access(FUNC_READ,  10'h2E8,    32'h0000_0000);
        send_access(FUNC_READ,  OFS_STATUS, 32'h0000_0000);
        // status offset write does not hide the run bits
        send_access(FUNC_WRITE, OFS_STATUS, 32'hA5A5_A5A5);
        send_access(FUNC_READ,  OFS_STATUS, 32'h0000_0000);
        send_access(FUNC_READ,  10'h013,    32'h0000_0000);
        send_access(FUNC_WRITE, 10'h3FF,    32'h1234_5678);
        send_access(FUNC_READ,  10'h3FC,    32'h0000_0000);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r          = $urandom_range(0, 99);
            quiet_send = ($urandom_range(0, 4) == 0);
            ch         = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, DEF_CHANNELS - 1);
            bank       = OFF_W'((ch + 1) << 8);
            if (r < 55) begin
                // burst of sample reads on one channel, the odd fill read among them
                len = $urandom_range(4, 16);
                repeat (len) begin
                    send_access(FUNC_READ,
                                bank | (($urandom_range(0, 9) == 0) ? OFF_W'(BANK_FILL)
                                                                   : OFF_W'(BANK_DATA)),
                                $urandom);
                end
            end else if (r < 65) begin
                send_access(FUNC_WRITE, OFS_START, $urandom | (32'd1 << ch));
            end else if (r < 70) begin
                send_access(FUNC_WRITE, OFS_STOP, $urandom);
            end else if (r < 78) begin
                send_access(FUNC_WRITE, bank | OFF_W'(BANK_ENABLE),
                            {31'($urandom_range(0, 32'h7FFF_FFFF)),
                             1'($urandom_range(0, 3) != 0)});
            end else if (r < 84) begin
                send_access(FUNC_READ, OFS_STATUS, $urandom);
            end else begin
                send_access(1'($urandom_range(0, 1)), OFF_W'($urandom_range(0, 1023)),
                            $urandom);
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[pdm_mic_register_model_unit.f]
rtl/pdmr_pkg.sv
rtl/pdmr_shadow.sv
rtl/pdm_mic_register_model_unit.sv
rtl/pdmr_checker.sv
bench/pdmr_access_checker.sv
bench/tb_pdm_mic_register_model_unit.sv
